// ----- src/bbdc_pkg.sv -----
// Shared types and constants for the block bitmap duplicate checker.
`timescale 1ns / 1ps

package bbdc_pkg;

	localparam int BLK_W             = 16;
	localparam int BYTE_IDX_W        = 13;
	localparam int BIT_SEL_W         = 3;
	localparam int CNT_W             = 20;
	localparam int DIST_W            = 17;
	localparam int VOL_W             = 17;
	localparam int CFG_INDEX_W       = 3;
	localparam int CFG_DATA_W        = 17;
	localparam int WATCH_REGS        = 6;
	localparam int BITMAP_BYTES_DEF  = 8192;
	localparam int WATCH_ENTRIES_DEF = 6;
	localparam int QUEUE_DEPTH       = 2;
	localparam int QUEUE_PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int S_TDATA_W         = 24;
	localparam int M_TDATA_W         = 64;

	localparam logic [CFG_INDEX_W-1:0] REG_INODE  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_VOLUME = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WATCH0 = 3'd2;

	localparam logic FUNC_CLEAR = 1'b0;
	localparam logic FUNC_CHECK = 1'b1;

	localparam logic [VOL_W-1:0] VOLUME_RESET = 17'd65536;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_RANGE = 2'd1,
		STATUS_DUP   = 2'd2,
		STATUS_CLEAR = 2'd3
	} status_t;

	typedef struct packed {
		logic                  is_clear;
		logic                  in_range;
		logic                  use_ref;
		logic                  hit;
		logic [BYTE_IDX_W-1:0] byte_idx;
		logic [BIT_SEL_W-1:0]  bit_sel;
	} item_t;

	typedef struct packed {
		logic [DIST_W-1:0] distinct_count;
		logic [CNT_W-1:0]  dup_count;
		logic [CNT_W-1:0]  used_count;
		logic              watch_hit;
		status_t           status;
	} result_t;

endpackage

// ----- src/bbdc_front.sv -----
// Front end: configuration registers and classification of incoming block references.
`timescale 1ns / 1ps

module bbdc_front #(
	parameter int BITMAP_BYTES  = bbdc_pkg::BITMAP_BYTES_DEF,
	parameter int WATCH_ENTRIES = bbdc_pkg::WATCH_ENTRIES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [bbdc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [bbdc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 func,
	input  logic [bbdc_pkg::BLK_W-1:0]           block_number,
	input  logic                                 counts_as_use,
	output bbdc_pkg::item_t                      item
);
	import bbdc_pkg::*;

	logic [BLK_W-1:0] inode_q;
	logic [VOL_W-1:0] volume_q;
	logic [BLK_W-1:0] watch_q [WATCH_ENTRIES];

	logic [VOL_W-1:0]      blk_ext;
	logic [VOL_W-1:0]      low_limit;
	logic [BYTE_IDX_W-1:0] byte_idx;
	logic                  in_range;
	logic                  hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inode_q  <= '0;
			volume_q <= VOLUME_RESET;
			for (int i = 0; i < WATCH_ENTRIES; i++) begin
				watch_q[i] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == REG_INODE) begin
				inode_q <= cfg_data[BLK_W-1:0];
			end
			if (cfg_index == REG_VOLUME) begin
				volume_q <= cfg_data[VOL_W-1:0];
			end
			for (int i = 0; i < WATCH_ENTRIES; i++) begin
				if (cfg_index == CFG_INDEX_W'(int'(REG_WATCH0) + i)) begin
					watch_q[i] <= cfg_data[BLK_W-1:0];
				end
			end
		end
	end

	always_comb begin
		blk_ext   = VOL_W'(block_number);
		low_limit = VOL_W'(inode_q) + VOL_W'(2);
		byte_idx  = block_number[BLK_W-1:BIT_SEL_W];
		in_range  = (blk_ext >= low_limit) && (blk_ext < volume_q) &&
			(32'(byte_idx) < 32'(BITMAP_BYTES));
		hit = 1'b0;
		for (int i = 0; i < WATCH_ENTRIES; i++) begin
			if ((watch_q[i] != '0) && (watch_q[i] == block_number)) begin
				hit = 1'b1;
			end
		end
		item.is_clear = (func == FUNC_CLEAR);
		item.in_range = in_range;
		item.use_ref  = counts_as_use;
		item.hit      = hit && in_range;
		item.byte_idx = byte_idx;
		item.bit_sel  = block_number[BIT_SEL_W-1:0];
	end

endmodule

// ----- src/bbdc_queue.sv -----
// Two-entry queue between the classifying front end and the bitmap back end.
`timescale 1ns / 1ps

module bbdc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bbdc_pkg::item_t push_item,
	input  logic            pop,
	output bbdc_pkg::item_t head,
	output logic            full,
	output logic            empty
);
	import bbdc_pkg::*;

	item_t                  slot_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   do_push;
	logic                   do_pop;

	assign full    = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- src/bbdc_back.sv -----
// Back end: bitmap memory, read-modify-write sequencer, counters and result register.
`timescale 1ns / 1ps

module bbdc_back #(
	parameter int BITMAP_BYTES = bbdc_pkg::BITMAP_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  bbdc_pkg::item_t   q_head,
	output logic              q_pop,
	output logic              res_valid,
	input  logic              res_ready,
	output bbdc_pkg::result_t res
);
	import bbdc_pkg::*;

	localparam int ADDR_W = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_MODIFY
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] sweep_addr_q;
	item_t             item_q;
	logic [CNT_W-1:0]  used_q;
	logic [CNT_W-1:0]  dup_q;
	logic [DIST_W-1:0] dist_q;
	logic              out_valid_q;
	result_t           res_q;

	logic [7:0]        bitmap_mem [BITMAP_BYTES];
	logic [7:0]        rd_data_q;

	logic              out_free;
	logic              is_dup;
	logic [CNT_W-1:0]  used_inc;
	logic [CNT_W-1:0]  used_nxt;
	logic [CNT_W-1:0]  dup_inc;
	logic [DIST_W-1:0] dist_inc;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [7:0]        mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;

	assign out_free  = !out_valid_q || res_ready;
	assign q_pop     = (state_q == ST_IDLE) && !q_empty && out_free;
	assign is_dup    = rd_data_q[item_q.bit_sel];
	assign used_inc  = (used_q == '1) ? used_q : used_q + 1'b1;
	assign used_nxt  = q_head.use_ref ? used_inc : used_q;
	assign dup_inc   = (dup_q == '1) ? dup_q : dup_q + 1'b1;
	assign dist_inc  = (dist_q == '1) ? dist_q : dist_q + 1'b1;
	assign res_valid = out_valid_q;
	assign res       = res_q;

	always_comb begin
		mem_re    = q_pop && !q_head.is_clear && q_head.in_range;
		mem_raddr = ADDR_W'(q_head.byte_idx);
		mem_we    = 1'b0;
		mem_waddr = sweep_addr_q;
		mem_wdata = '0;
		case (state_q)
			ST_SWEEP: begin
				mem_we = 1'b1;
			end
			ST_MODIFY: begin
				mem_we    = !is_dup;
				mem_waddr = ADDR_W'(item_q.byte_idx);
				mem_wdata = rd_data_q | (8'd1 << item_q.bit_sel);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bitmap_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= bitmap_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			sweep_addr_q <= '0;
			used_q       <= '0;
			dup_q        <= '0;
			dist_q       <= '0;
			out_valid_q  <= 1'b0;
			res_q        <= '0;
		end else begin
			if (out_valid_q && res_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_SWEEP: begin
					sweep_addr_q <= sweep_addr_q + 1'b1;
					if (sweep_addr_q == ADDR_W'(BITMAP_BYTES - 1)) begin
						sweep_addr_q <= '0;
						state_q      <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_pop) begin
						if (q_head.is_clear) begin
							used_q               <= '0;
							dup_q                <= '0;
							dist_q               <= '0;
							sweep_addr_q         <= '0;
							state_q              <= ST_SWEEP;
							out_valid_q          <= 1'b1;
							res_q.status         <= STATUS_CLEAR;
							res_q.watch_hit      <= 1'b0;
							res_q.used_count     <= '0;
							res_q.dup_count      <= '0;
							res_q.distinct_count <= '0;
						end else if (!q_head.in_range) begin
							used_q               <= used_nxt;
							out_valid_q          <= 1'b1;
							res_q.status         <= STATUS_RANGE;
							res_q.watch_hit      <= 1'b0;
							res_q.used_count     <= used_nxt;
							res_q.dup_count      <= dup_q;
							res_q.distinct_count <= dist_q;
						end else begin
							used_q  <= used_nxt;
							state_q <= ST_MODIFY;
						end
					end
				end
				ST_MODIFY: begin
					state_q          <= ST_IDLE;
					out_valid_q      <= 1'b1;
					res_q.watch_hit  <= item_q.hit;
					res_q.used_count <= used_q;
					if (is_dup) begin
						dup_q                <= dup_inc;
						res_q.status         <= STATUS_DUP;
						res_q.dup_count      <= dup_inc;
						res_q.distinct_count <= dist_q;
					end else begin
						dist_q               <= dist_inc;
						res_q.status         <= STATUS_OK;
						res_q.dup_count      <= dup_q;
						res_q.distinct_count <= dist_inc;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/block_bitmap_duplicate_checker_unit.sv -----
// Top level of the block bitmap duplicate checker.
//
// Block references arrive on the s_ stream: tuser carries the command (clear or
// check) and tdata the block number and the use flag. Each transaction yields
// exactly one result transaction on the m_ stream with the status in tuser and
// the watch flag and the three counters in tdata.
// A front end classifies each reference against the configuration registers and
// places it in a two-entry queue; the back end performs the bitmap access.
// An out-of-range reference is finished in the back end's idle state; an in-range
// one also passes through the modify state (registered memory read, then the
// write and the result). The back end takes the next reference only in the idle
// state and only while the result register is free.
// A clear command returns its result at once, then zeroes the bitmap one byte per
// cycle, covering all BITMAP_BYTES bytes, before the next reference is processed.
// After reset the same sweep runs; input transactions are queued meanwhile and
// configuration writes are taken at any time.
// When the receiver stalls, the result register holds and the queue fills, after
// which s_tready falls until the receiver takes the pending result.
`timescale 1ns / 1ps

module block_bitmap_duplicate_checker_unit #(
	parameter int BITMAP_BYTES  = bbdc_pkg::BITMAP_BYTES_DEF,
	parameter int WATCH_ENTRIES = bbdc_pkg::WATCH_ENTRIES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bbdc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [bbdc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// block_number [15:0], counts_as_use [16], zero padding [23:17]
	input  logic [bbdc_pkg::S_TDATA_W-1:0]      s_tdata,
	// func [0]
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// watch_hit [0], used_count [20:1], dup_count [40:21],
	// distinct_count [57:41], zero padding [63:58]
	output logic [bbdc_pkg::M_TDATA_W-1:0]      m_tdata,
	// status [1:0]
	output logic [1:0]                          m_tuser
);
	import bbdc_pkg::*;

	item_t   front_item;
	item_t   q_head;
	logic    q_full;
	logic    q_empty;
	logic    q_pop;
	result_t res;

	assign s_tready = !q_full;

	bbdc_front #(
		.BITMAP_BYTES (BITMAP_BYTES),
		.WATCH_ENTRIES(WATCH_ENTRIES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.func         (s_tuser),
		.block_number (s_tdata[BLK_W-1:0]),
		.counts_as_use(s_tdata[BLK_W]),
		.item         (front_item)
	);

	bbdc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (s_tvalid),
		.push_item(front_item),
		.pop      (q_pop),
		.head     (q_head),
		.full     (q_full),
		.empty    (q_empty)
	);

	bbdc_back #(
		.BITMAP_BYTES(BITMAP_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.res_valid(m_tvalid),
		.res_ready(m_tready),
		.res      (res)
	);

	assign m_tuser = res.status;
	assign m_tdata = {
		6'd0,
		res.distinct_count,
		res.dup_count,
		res.used_count,
		res.watch_hit
	};

endmodule

// ----- tb/tb_block_bitmap_duplicate_checker_unit.sv -----
// Self-checking testbench for the block bitmap duplicate checker with a built-in bitmap predictor.
`timescale 1ns / 1ps

module tb_block_bitmap_duplicate_checker_unit;
	import bbdc_pkg::*;

	localparam int CLK_HALF      = 6;
	localparam int RUN_LIMIT     = 1000000;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 60;
	localparam int CLEAR_CAP     = 12;
	localparam int STALL_STRETCH = 150;
	localparam int BLK_MAX       = (1 << BLK_W) - 1;
	localparam int VOL_MAX       = 1 << BLK_W;
	localparam int CNT_MAX       = (1 << CNT_W) - 1;
	localparam int DISTINCT_MAX  = (1 << DIST_W) - 1;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

	typedef struct {
		row_kind_t              kind;
		logic [CFG_INDEX_W-1:0] reg_idx;
		int                     reg_val;
		logic                   func;
		logic [BLK_W-1:0]       blk;
		logic                   use_ref;
		logic                   typed;
		result_t                want;
	} row_t;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata   = '0;
	logic                   s_tuser   = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic [1:0]             m_tuser;

	int          inode_cfg  = 0;
	int          volume_cfg = VOL_MAX;
	logic [15:0] watch_cfg [WATCH_REGS];
	bit          block_seen [0:BLK_MAX];
	int          used_total;
	int          dup_total;
	int          distinct_total;

	result_t pending_reports [$];
	row_t    script [$];
	int      mismatches;
	int      cycle_count;
	bit      tx_burst;
	bit      rx_burst;
	int      rx_hold_len;

	block_bitmap_duplicate_checker_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic result_t mark_block(input logic func, input logic [BLK_W-1:0] blk,
			input logic use_ref);
		result_t r;
		int      i;
		r = '0;
		if (func == FUNC_CLEAR) begin
			foreach (block_seen[b])
				block_seen[b] = 1'b0;
			used_total     = 0;
			dup_total      = 0;
			distinct_total = 0;
			r.status       = STATUS_CLEAR;
		end else begin
			if (use_ref && used_total < CNT_MAX)
				used_total++;
			if (int'(blk) < inode_cfg + 2 || int'(blk) >= volume_cfg ||
					(int'(blk) >> 3) >= BITMAP_BYTES_DEF) begin
				r.status = STATUS_RANGE;
			end else begin
				if (block_seen[blk]) begin
					r.status = STATUS_DUP;
					if (dup_total < CNT_MAX)
						dup_total++;
				end else begin
					r.status        = STATUS_OK;
					block_seen[blk] = 1'b1;
					if (distinct_total < DISTINCT_MAX)
						distinct_total++;
				end
				for (i = 0; i < WATCH_ENTRIES_DEF; i++)
					if (watch_cfg[i] != '0 && watch_cfg[i] == blk)
						r.watch_hit = 1'b1;
			end
		end
		r.used_count     = used_total[CNT_W-1:0];
		r.dup_count      = dup_total[CNT_W-1:0];
		r.distinct_count = distinct_total[DIST_W-1:0];
		return r;
	endfunction

	function automatic row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx, input int val);
		row_t r;
		r.kind    = ROW_CFG;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	function automatic row_t item_row(input logic func, input int blk, input logic use_ref);
		row_t r;
		r.kind    = ROW_ITEM;
		r.func    = func;
		r.blk     = blk[BLK_W-1:0];
		r.use_ref = use_ref;
		r.typed   = 1'b0;
		r.want    = '0;
		return r;
	endfunction

	function automatic row_t known_row(input logic func, input int blk, input logic use_ref,
			input status_t st, input logic hit, input int used, input int dup,
			input int distinct);
		row_t r;
		r                     = item_row(func, blk, use_ref);
		r.typed               = 1'b1;
		r.want.status         = st;
		r.want.watch_hit      = hit;
		r.want.used_count     = used[CNT_W-1:0];
		r.want.dup_count      = dup[CNT_W-1:0];
		r.want.distinct_count = distinct[DIST_W-1:0];
		return r;
	endfunction

	function automatic logic [BLK_W-1:0] pick_block();
		int lo;
		int bound;
		lo = inode_cfg + 2;
		if (lo > BLK_MAX - 48)
			lo = BLK_MAX - 48;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return BLK_W'(lo + $urandom_range(0, 47));
			5: return watch_cfg[$urandom_range(0, WATCH_REGS - 1)];
			6: begin
				case ($urandom_range(0, 3))
					0: bound = inode_cfg + 1;
					1: bound = inode_cfg + 2;
					2: bound = volume_cfg - 1;
					default: bound = volume_cfg;
				endcase
				if (bound < 0)
					bound = 0;
				if (bound > BLK_MAX)
					bound = BLK_MAX;
				return BLK_W'(bound);
			end
			default: return BLK_W'($urandom_range(0, BLK_MAX));
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_DATA_W-1:0];
		if (idx == REG_INODE)
			inode_cfg = val & BLK_MAX;
		else if (idx == REG_VOLUME)
			volume_cfg = val & ((1 << VOL_W) - 1);
		else if (idx >= REG_WATCH0)
			watch_cfg[idx - REG_WATCH0] = val[15:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_txn(input logic func, input logic [BLK_W-1:0] blk, input logic use_ref,
			input logic typed, input result_t want);
		int      gap;
		result_t model;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= S_TDATA_W'({use_ref, blk});
		do
			@(posedge clk);
		while (s_tready !== 1'b1);
		model = mark_block(func, blk, use_ref);
		pending_reports.push_back(typed ? want : model);
		gap = tx_burst ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic random_setup();
		int ino;
		int vol;
		int w;
		int i;
		case ($urandom_range(0, 7))
			0: ino = 0;
			1: ino = BLK_MAX;
			default: ino = $urandom_range(0, 3000);
		endcase
		case ($urandom_range(0, 7))
			0: vol = VOL_MAX;
			1: vol = 0;
			2: vol = $urandom_range(0, VOL_MAX);
			default: vol = ino + $urandom_range(40, 600);
		endcase
		if (vol > VOL_MAX)
			vol = VOL_MAX;
		write_reg(REG_INODE, ino);
		write_reg(REG_VOLUME, vol);
		for (i = 0; i < WATCH_REGS; i++) begin
			case ($urandom_range(0, 3))
				0: w = 0;
				1: w = $urandom_range(0, BLK_MAX);
				default: w = ino + 2 + $urandom_range(0, 47);
			endcase
			if (w > BLK_MAX)
				w = BLK_MAX;
			write_reg(CFG_INDEX_W'(REG_WATCH0 + i), w);
		end
	endtask

	task automatic compare_report(input result_t want);
		result_t seen;
		seen.status         = status_t'(m_tuser);
		seen.watch_hit      = m_tdata[0];
		seen.used_count     = m_tdata[20:1];
		seen.dup_count      = m_tdata[40:21];
		seen.distinct_count = m_tdata[57:41];
		if (seen.status !== want.status) begin
			$display("%0t: status expected %s, actual %0d", $time, want.status.name(), m_tuser);
			mismatches++;
		end
		if (seen.watch_hit !== want.watch_hit) begin
			$display("%0t: watch_hit expected %0b, actual %0b", $time, want.watch_hit,
				seen.watch_hit);
			mismatches++;
		end
		if (seen.used_count !== want.used_count) begin
			$display("%0t: used_count expected %0d, actual %0d", $time, want.used_count,
				seen.used_count);
			mismatches++;
		end
		if (seen.dup_count !== want.dup_count) begin
			$display("%0t: dup_count expected %0d, actual %0d", $time, want.dup_count,
				seen.dup_count);
			mismatches++;
		end
		if (seen.distinct_count !== want.distinct_count) begin
			$display("%0t: distinct_count expected %0d, actual %0d", $time,
				want.distinct_count, seen.distinct_count);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			if (pending_reports.size() == 0) begin
				$display("%0t: result transaction expected none, actual status %0d tdata %h",
					$time, m_tuser, m_tdata);
				mismatches++;
			end else begin
				compare_report(pending_reports.pop_front());
			end
		end
	end

	initial begin
		int stall;
		forever begin
			if (rx_hold_len > 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (rx_hold_len) @(negedge clk);
				rx_hold_len = 0;
			end
			stall = rx_burst ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do
				@(posedge clk);
			while (m_tvalid !== 1'b1);
			if ($urandom_range(0, 19) == 0)
				rx_burst = !rx_burst;
		end
	end

	initial begin
		int p;
		int n;
		int clears;
		logic func;
		foreach (watch_cfg[i])
			watch_cfg[i] = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		script.push_back(cfg_row(REG_INODE, 10));
		script.push_back(cfg_row(REG_VOLUME, 1000));
		script.push_back(cfg_row(REG_WATCH0, 100));
		script.push_back(cfg_row(CFG_INDEX_W'(REG_WATCH0 + 1), 0));
		script.push_back(cfg_row(CFG_INDEX_W'(REG_WATCH0 + 2), 300));
		script.push_back(cfg_row(CFG_INDEX_W'(REG_WATCH0 + 3), 0));
		script.push_back(cfg_row(CFG_INDEX_W'(REG_WATCH0 + 4), 500));
		script.push_back(cfg_row(CFG_INDEX_W'(REG_WATCH0 + 5), 999));
		script.push_back(known_row(FUNC_CHECK, 11, 1'b1, STATUS_RANGE, 1'b0, 1, 0, 0));
		script.push_back(known_row(FUNC_CHECK, 12, 1'b0, STATUS_OK, 1'b0, 1, 0, 1));
		script.push_back(known_row(FUNC_CHECK, 999, 1'b1, STATUS_OK, 1'b1, 2, 0, 2));
		script.push_back(known_row(FUNC_CHECK, 1000, 1'b1, STATUS_RANGE, 1'b0, 3, 0, 2));
		script.push_back(known_row(FUNC_CHECK, 12, 1'b1, STATUS_DUP, 1'b0, 4, 1, 2));
		script.push_back(known_row(FUNC_CHECK, 100, 1'b0, STATUS_OK, 1'b1, 4, 1, 3));
		script.push_back(known_row(FUNC_CHECK, 100, 1'b1, STATUS_DUP, 1'b1, 5, 2, 3));
		script.push_back(known_row(FUNC_CHECK, 0, 1'b1, STATUS_RANGE, 1'b0, 6, 2, 3));
		script.push_back(known_row(FUNC_CHECK, BLK_MAX, 1'b0, STATUS_RANGE, 1'b0, 6, 2, 3));
		script.push_back(item_row(FUNC_CHECK, 300, 1'b0));
		script.push_back(item_row(FUNC_CHECK, 500, 1'b1));
		script.push_back(item_row(FUNC_CHECK, 13, 1'b0));
		script.push_back(known_row(FUNC_CLEAR, BLK_MAX, 1'b1, STATUS_CLEAR, 1'b0, 0, 0, 0));
		script.push_back(known_row(FUNC_CHECK, 12, 1'b1, STATUS_OK, 1'b0, 1, 0, 1));
		script.push_back(known_row(FUNC_CHECK, 12, 1'b0, STATUS_DUP, 1'b0, 1, 1, 1));
		script.push_back(cfg_row(REG_INODE, 0));
		script.push_back(cfg_row(REG_VOLUME, VOL_MAX));
		script.push_back(cfg_row(REG_WATCH0, BLK_MAX));
		script.push_back(cfg_row(CFG_INDEX_W'(REG_WATCH0 + 1), 2));
		script.push_back(item_row(FUNC_CHECK, 0, 1'b1));
		script.push_back(item_row(FUNC_CHECK, 1, 1'b0));
		script.push_back(item_row(FUNC_CHECK, 2, 1'b1));
		script.push_back(item_row(FUNC_CHECK, BLK_MAX, 1'b1));
		script.push_back(item_row(FUNC_CHECK, BLK_MAX, 1'b0));
		script.push_back(cfg_row(REG_INODE, BLK_MAX));
		script.push_back(item_row(FUNC_CHECK, BLK_MAX, 1'b1));
		script.push_back(cfg_row(REG_INODE, 0));
		script.push_back(cfg_row(REG_VOLUME, 0));
		script.push_back(item_row(FUNC_CHECK, 2, 1'b1));
		script.push_back(cfg_row(REG_VOLUME, VOL_MAX));
		script.push_back(known_row(FUNC_CLEAR, 0, 1'b0, STATUS_CLEAR, 1'b0, 0, 0, 0));

		foreach (script[r]) begin
			if (script[r].kind == ROW_CFG) begin
				settle();
				write_reg(script[r].reg_idx, script[r].reg_val);
			end else begin
				send_txn(script[r].func, script[r].blk, script[r].use_ref, script[r].typed,
					script[r].want);
			end
		end

		// The third phase backs up the result side while the source keeps streaming.
		clears = 0;
		for (p = 0; p < PHASES; p++) begin
			settle();
			random_setup();
			tx_burst = (p == 2) || ($urandom_range(0, 3) == 0);
			if (p == 2)
				rx_hold_len = STALL_STRETCH;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				func = FUNC_CHECK;
				if (clears < CLEAR_CAP && $urandom_range(0, 63) == 0) begin
					func = FUNC_CLEAR;
					clears++;
				end
				send_txn(func, pick_block(), 1'($urandom_range(0, 1)), 1'b0, '0);
			end
		end

		settle();
		repeat (10) @(posedge clk);
		if (pending_reports.size() != 0)
			$display("%0t: %0d result transactions expected, none arrived", $time,
				pending_reports.size());
		if (mismatches == 0 && pending_reports.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
